// ===== rtl/tpgc_pkg.sv =====
// tpgc_pkg: shared widths, codes and payload types of the two-player game clock
// no dependencies; imported by every rtl module of the block
package tpgc_pkg;

  localparam int unsigned TimeW    = 26;
  localparam int unsigned IncW     = 20;
  localparam int unsigned ElapW    = 10;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned SideW    = 2;
  localparam int unsigned FlagW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 26;

  localparam logic [TimeW-1:0] MAX_TIME_MS = 26'd36000000;
  localparam logic [IncW-1:0]  MAX_INC_MS  = 20'd600000;

  // timing modes as latched at new game
  localparam logic [ModeW-1:0] MODE_NONE      = 3'd0;
  localparam logic [ModeW-1:0] MODE_SUDDEN    = 3'd1;
  localparam logic [ModeW-1:0] MODE_FISCHER   = 3'd2;
  localparam logic [ModeW-1:0] MODE_DELAY     = 3'd3;
  localparam logic [ModeW-1:0] MODE_BRONSTEIN = 3'd4;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] REG_TIME_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BASE_TIME = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INCREMENT = 2'd2;

  localparam logic [SideW-1:0] SIDE_WHITE = 2'd0;
  localparam logic [SideW-1:0] SIDE_BLACK = 2'd1;

  localparam logic [FlagW-1:0] FLAG_NONE  = 2'd0;
  localparam logic [FlagW-1:0] FLAG_WHITE = 2'd1;
  localparam logic [FlagW-1:0] FLAG_BLACK = 2'd2;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 3'd0,
    CMD_MOVE  = 3'd1,
    CMD_START = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_NEW   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [SideW-1:0] side;
    logic [ElapW-1:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [TimeW-1:0] white_time_ms;
    logic [TimeW-1:0] black_time_ms;
    logic             is_running;
    logic [FlagW-1:0] timeout_side;
  } result_t;

  typedef struct packed {
    logic [ModeW-1:0] time_mode;
    logic [TimeW-1:0] base_time_ms;
    logic [IncW-1:0]  increment_ms;
  } cfg_t;

endpackage

// ===== rtl/tpgc_cfg.sv =====
// tpgc_cfg: configuration registers (mode, base time, increment)
// depends on tpgc_pkg
module tpgc_cfg
  import tpgc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TIME_MODE: cfg_d.time_mode    = cfg_data_i[ModeW-1:0];
        REG_BASE_TIME: cfg_d.base_time_ms = cfg_data_i[TimeW-1:0];
        REG_INCREMENT: cfg_d.increment_ms = cfg_data_i[IncW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_mode    <= MODE_FISCHER;
      cfg_q.base_time_ms <= 26'd300000;
      cfg_q.increment_ms <= 20'd3000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/tpgc_core.sv =====
// tpgc_core: clock state registers and the per-command update logic
// depends on tpgc_pkg; result is the state after the stepped item
module tpgc_core
  import tpgc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [TimeW-1:0] white_q, white_d;
  logic [TimeW-1:0] black_q, black_d;
  logic [IncW-1:0]  delay_q, delay_d;
  logic [TimeW-1:0] mst_q, mst_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [IncW-1:0]  inc_q, inc_d;
  logic             run_q, run_d;
  logic             wflag_q, wflag_d;
  logic             bflag_q, bflag_d;

  // tick datapath
  logic             delay_active;
  logic             delay_absorbs;
  logic [ElapW-1:0] dt_eff;
  logic [TimeW-1:0] dt_wide;

  // move datapath
  logic [TimeW-1:0] mine;
  logic [TimeW-1:0] other;
  logic [TimeW-1:0] gain_raw;
  logic [IncW-1:0]  gain;
  logic [IncW-1:0]  addend;
  logic [TimeW:0]   mine_sum;
  logic [TimeW-1:0] mine_sat;

  always_comb begin
    delay_active  = (mode_q == MODE_DELAY) && (delay_q != '0);
    delay_absorbs = delay_active && ({{(IncW-ElapW){1'b0}}, item_i.elapsed_ms} <= delay_q);
    // excess over the delay; delay is below elapsed here so it fits
    dt_eff  = delay_active ? (item_i.elapsed_ms - delay_q[ElapW-1:0]) : item_i.elapsed_ms;
    dt_wide = {{(TimeW-ElapW){1'b0}}, dt_eff};
  end

  always_comb begin
    mine     = (item_i.side == SIDE_WHITE) ? white_q : black_q;
    other    = (item_i.side == SIDE_WHITE) ? black_q : white_q;
    gain_raw = (mst_q > mine) ? (mst_q - mine) : '0;
    gain     = (gain_raw > {{(TimeW-IncW){1'b0}}, inc_q}) ? inc_q : gain_raw[IncW-1:0];
    addend   = (mode_q == MODE_BRONSTEIN) ? gain : inc_q;
    mine_sum = {1'b0, mine} + {{(TimeW-IncW+1){1'b0}}, addend};
    mine_sat = (mine_sum > {1'b0, MAX_TIME_MS}) ? MAX_TIME_MS : mine_sum[TimeW-1:0];
  end

  always_comb begin
    white_d = white_q;
    black_d = black_q;
    delay_d = delay_q;
    mst_d   = mst_q;
    mode_d  = mode_q;
    inc_d   = inc_q;
    run_d   = run_q;
    wflag_d = wflag_q;
    bflag_d = bflag_q;
    unique case (item_i.cmd)
      CMD_TICK: begin
        if (run_q && (mode_q != MODE_NONE)) begin
          if (delay_absorbs) begin
            delay_d = delay_q - {{(IncW-ElapW){1'b0}}, item_i.elapsed_ms};
          end else begin
            if (delay_active) begin
              delay_d = '0;
            end
            if (item_i.side == SIDE_WHITE) begin
              if (white_q <= dt_wide) begin
                white_d = '0;
                wflag_d = 1'b1;
                run_d   = 1'b0;
              end else begin
                white_d = white_q - dt_wide;
              end
            end else if (item_i.side == SIDE_BLACK) begin
              if (black_q <= dt_wide) begin
                black_d = '0;
                bflag_d = 1'b1;
                run_d   = 1'b0;
              end else begin
                black_d = black_q - dt_wide;
              end
            end
          end
        end
      end
      CMD_MOVE: begin
        if (mode_q == MODE_DELAY) begin
          delay_d = inc_q;
        end else if ((mode_q == MODE_FISCHER) || (mode_q == MODE_BRONSTEIN)) begin
          if (item_i.side == SIDE_WHITE) begin
            white_d = mine_sat;
          end else if (item_i.side == SIDE_BLACK) begin
            black_d = mine_sat;
          end
          // bronstein remembers the opponent's time for the next move
          if ((mode_q == MODE_BRONSTEIN) &&
              ((item_i.side == SIDE_WHITE) || (item_i.side == SIDE_BLACK))) begin
            mst_d = other;
          end
        end
      end
      CMD_START: begin
        if (mode_q != MODE_NONE) begin
          run_d = 1'b1;
          if (mode_q == MODE_DELAY) begin
            delay_d = inc_q;
          end
          if (mode_q == MODE_BRONSTEIN) begin
            mst_d = white_q;
          end
        end
      end
      CMD_STOP: begin
        run_d = 1'b0;
      end
      CMD_NEW: begin
        mode_d  = cfg_i.time_mode;
        inc_d   = (cfg_i.increment_ms > MAX_INC_MS) ? MAX_INC_MS : cfg_i.increment_ms;
        white_d = (cfg_i.base_time_ms > MAX_TIME_MS) ? MAX_TIME_MS : cfg_i.base_time_ms;
        black_d = (cfg_i.base_time_ms > MAX_TIME_MS) ? MAX_TIME_MS : cfg_i.base_time_ms;
        delay_d = '0;
        mst_d   = '0;
        run_d   = 1'b0;
        wflag_d = 1'b0;
        bflag_d = 1'b0;
      end
      default: begin
        // unknown command codes leave the state alone
        run_d = run_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q <= '0;
      black_q <= '0;
      delay_q <= '0;
      mst_q   <= '0;
      mode_q  <= MODE_NONE;
      inc_q   <= '0;
      run_q   <= 1'b0;
      wflag_q <= 1'b0;
      bflag_q <= 1'b0;
    end else if (step_i) begin
      white_q <= white_d;
      black_q <= black_d;
      delay_q <= delay_d;
      mst_q   <= mst_d;
      mode_q  <= mode_d;
      inc_q   <= inc_d;
      run_q   <= run_d;
      wflag_q <= wflag_d;
      bflag_q <= bflag_d;
    end
  end

  always_comb begin
    result_o.white_time_ms = white_d;
    result_o.black_time_ms = black_d;
    result_o.is_running    = run_d;
    priority if (wflag_d) begin
      result_o.timeout_side = FLAG_WHITE;
    end else if (bflag_d) begin
      result_o.timeout_side = FLAG_BLACK;
    end else begin
      result_o.timeout_side = FLAG_NONE;
    end
  end

endmodule

// ===== rtl/two_player_game_clock.sv =====
// two_player_game_clock: top level of the two-player game clock
// depends on tpgc_pkg, tpgc_cfg and tpgc_core
//
// Two-player countdown clock in integer milliseconds with sudden death, Fischer,
// simple delay and Bronstein timing. Each input item is one command (tick, move
// made, start, stop, new game) and returns exactly one result item holding both
// remaining times, the running bit and the flagged side after that command.
// The block takes one item per clock cycle while out_stall_i is low: the item is
// captured in an input register, and the clock state and the result register
// update together when it advances, so the next item already sees the updated
// state. A stalled result holds the result register; the input register then
// holds one more item before in_stall_o rises. Configuration registers only take
// effect at the next new-game command and are to be written only while the block
// is idle; the block itself does not enforce this.
module two_player_game_clock
  import tpgc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // command item channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [SideW-1:0]    side_i,
  input  logic [ElapW-1:0]    elapsed_ms_i,
  // result item channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [TimeW-1:0]    white_time_ms_o,
  output logic [TimeW-1:0]    black_time_ms_o,
  output logic                is_running_o,
  output logic [FlagW-1:0]    timeout_side_o
);

  cfg_t    cfg;
  item_t   item_q, item_d;
  logic    in_valid_q, in_valid_d;
  result_t result_q, result_d;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    in_take;

  tpgc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the held item moves into the state whenever the result register is free
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  tpgc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  // input register
  always_comb begin
    item_d     = in_take ? {cmd_i, side_i, elapsed_ms_i} : item_q;
    in_valid_d = in_take || (in_valid_q && !advance);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  // result register
  always_comb begin
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign white_time_ms_o = result_q.white_time_ms;
  assign black_time_ms_o = result_q.black_time_ms;
  assign is_running_o    = result_q.is_running;
  assign timeout_side_o  = result_q.timeout_side;

  // times never leave the saturation range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (white_time_ms_o <= MAX_TIME_MS) && (black_time_ms_o <= MAX_TIME_MS))
    else $error("remaining time above maximum");

  // flag code is never the unused encoding
  a_flag_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (timeout_side_o != 2'd3))
    else $error("bad timeout code");

  // a stop item always reports a stopped clock
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (item_q.cmd == CMD_STOP) |=> out_valid_o && !is_running_o)
    else $error("clock running after stop");

  // new game clears flags and stops the clock
  a_new_game: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (item_q.cmd == CMD_NEW) |=>
      out_valid_o && !is_running_o && (timeout_side_o == FLAG_NONE))
    else $error("new game left flags or running set");

endmodule

// ===== test/two_player_game_clock_tb.sv =====
// two_player_game_clock_tb: self-checking testbench for the two-player game clock
// drives command items, predicts every result item with its own clock model and
// compares field by field; depends on tpgc_pkg and two_player_game_clock
module two_player_game_clock_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpgc_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned QuietLimit = 4000;
  // codes outside the defined sets
  localparam logic [CmdW-1:0]  CMD_RSVD  = 3'd5;
  localparam logic [ModeW-1:0] MODE_RSVD = 3'd5;
  localparam logic [SideW-1:0] SIDE_NONE = 2'd2;
  localparam logic [SideW-1:0] SIDE_BAD  = 2'd3;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic [CmdW-1:0]     cmd_i        = '0;
  logic [SideW-1:0]    side_i       = '0;
  logic [ElapW-1:0]    elapsed_ms_i = '0;
  logic                out_stall_i  = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [TimeW-1:0]    white_time_ms_o;
  logic [TimeW-1:0]    black_time_ms_o;
  logic                is_running_o;
  logic [FlagW-1:0]    timeout_side_o;

  two_player_game_clock dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .side_i         (side_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .white_time_ms_o(white_time_ms_o),
    .black_time_ms_o(black_time_ms_o),
    .is_running_o   (is_running_o),
    .timeout_side_o (timeout_side_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // register copies as written on the config port, reset values
  logic [ModeW-1:0] next_mode = MODE_FISCHER;
  logic [TimeW-1:0] next_base = 26'd300000;
  logic [IncW-1:0]  next_inc  = 20'd3000;

  // predicted clock state, as the block holds it after reset
  logic [TimeW-1:0] white_ms      = '0;
  logic [TimeW-1:0] black_ms      = '0;
  logic [IncW-1:0]  delay_ms      = '0;
  logic [TimeW-1:0] move_mark_ms  = '0;
  logic [ModeW-1:0] game_mode     = MODE_NONE;
  logic [IncW-1:0]  game_inc      = '0;
  logic             running       = 1'b0;
  logic             white_flagged = 1'b0;
  logic             black_flagged = 1'b0;

  item_t       cmd_backlog[$];     // items waiting for the driver
  result_t     clock_readings[$];  // predicted results, oldest first
  int unsigned cmds_owed    = 0;   // items queued but not yet accepted
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        in_taken      = 1'b0;  // item accepted at the last rising edge

  // times saturate at the top of the range
  function automatic logic [TimeW-1:0] cap_time(input int unsigned t);
    return (t > MAX_TIME_MS) ? MAX_TIME_MS : TimeW'(t);
  endfunction

  // count one side down; reaching zero or below flags it and stops the clock
  function automatic void run_down(inout logic [TimeW-1:0] t, inout logic flag,
                                   input int unsigned dt);
    if (t <= dt) begin
      t       = '0;
      flag    = 1'b1;
      running = 1'b0;
    end else begin
      t = t - TimeW'(dt);
    end
  endfunction

  // apply one command to the predicted clock and return the reading after it
  function automatic result_t advance_clock(input item_t it);
    int unsigned      dt;
    int unsigned      gain;
    bit               delay_covers;
    logic [TimeW-1:0] mover;
    logic [TimeW-1:0] other;
    result_t          r;
    dt           = 32'(it.elapsed_ms);
    delay_covers = 1'b0;
    case (cmd_e'(it.cmd))
      CMD_TICK: begin
        if (running && game_mode != MODE_NONE) begin
          // simple delay is spent first, only the excess reaches the main time
          if (game_mode == MODE_DELAY && delay_ms != '0) begin
            if (dt <= delay_ms) begin
              delay_ms     = delay_ms - IncW'(dt);
              delay_covers = 1'b1;
            end else begin
              dt       = dt - delay_ms;
              delay_ms = '0;
            end
          end
          if (!delay_covers) begin
            if (it.side == SIDE_WHITE) run_down(white_ms, white_flagged, dt);
            else if (it.side == SIDE_BLACK) run_down(black_ms, black_flagged, dt);
          end
        end
      end
      CMD_MOVE: begin
        // the mode rule applies even when stopped or flagged
        if (game_mode == MODE_FISCHER) begin
          if (it.side == SIDE_WHITE) white_ms = cap_time(white_ms + game_inc);
          else if (it.side == SIDE_BLACK) black_ms = cap_time(black_ms + game_inc);
        end else if (game_mode == MODE_DELAY) begin
          delay_ms = game_inc;
        end else if (game_mode == MODE_BRONSTEIN &&
                     (it.side == SIDE_WHITE || it.side == SIDE_BLACK)) begin
          mover = (it.side == SIDE_WHITE) ? white_ms : black_ms;
          other = (it.side == SIDE_WHITE) ? black_ms : white_ms;
          gain  = (move_mark_ms > mover) ? move_mark_ms - mover : 0;
          if (gain > game_inc) gain = 32'(game_inc);
          mover = cap_time(mover + gain);
          if (it.side == SIDE_WHITE) white_ms = mover;
          else black_ms = mover;
          move_mark_ms = other;
        end
      end
      CMD_START: begin
        if (game_mode != MODE_NONE) begin
          running = 1'b1;
          if (game_mode == MODE_DELAY) delay_ms = game_inc;
          if (game_mode == MODE_BRONSTEIN) move_mark_ms = white_ms;
        end
      end
      CMD_STOP: running = 1'b0;
      CMD_NEW: begin
        game_mode     = next_mode;
        game_inc      = (next_inc > MAX_INC_MS) ? MAX_INC_MS : next_inc;
        white_ms      = cap_time(next_base);
        black_ms      = white_ms;
        delay_ms      = '0;
        move_mark_ms  = '0;
        running       = 1'b0;
        white_flagged = 1'b0;
        black_flagged = 1'b0;
      end
      default: ;  // unused command codes leave the state alone
    endcase
    r.white_time_ms = white_ms;
    r.black_time_ms = black_ms;
    r.is_running    = running;
    r.timeout_side  = white_flagged ? FLAG_WHITE : (black_flagged ? FLAG_BLACK : FLAG_NONE);
    return r;
  endfunction

  task automatic log_mismatch(input string what, input longint unsigned got,
                              input longint unsigned want);
    mismatches++;
    // keep the log short on a badly broken block
    if (mismatches <= 100)
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // command driver: a held item stays put until accepted, new items go out
  // on the falling edge unless the sender decides to idle this cycle
  always @(negedge clk_i) begin : cmd_driver
    item_t nxt;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        in_valid_i   <= 1'b1;
        cmd_i        <= nxt.cmd;
        side_i       <= nxt.side;
        elapsed_ms_i <= nxt.elapsed_ms;
      end else begin
        // payload is don't-care while valid is low, so scramble it
        in_valid_i   <= 1'b0;
        cmd_i        <= CmdW'($urandom);
        side_i       <= SideW'($urandom);
        elapsed_ms_i <= ElapW'($urandom);
      end
    end
  end

  // result stall, redrawn every cycle
  always @(negedge clk_i) begin : stall_driver
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < stall_pct);
  end

  // every accepted command advances the predicted clock by one step
  always @(posedge clk_i) begin : cmd_monitor
    item_t seen;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen.cmd        = cmd_i;
      seen.side       = side_i;
      seen.elapsed_ms = elapsed_ms_i;
      clock_readings.push_back(advance_clock(seen));
      cmds_owed--;
    end
  end

  // every accepted result is checked against the oldest prediction
  always @(posedge clk_i) begin : reading_monitor
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (clock_readings.size() == 0) begin
        log_mismatch("result item with nothing expected", 1, 0);
      end else begin
        want = clock_readings.pop_front();
        if (white_time_ms_o !== want.white_time_ms)
          log_mismatch("white_time_ms", white_time_ms_o, want.white_time_ms);
        if (black_time_ms_o !== want.black_time_ms)
          log_mismatch("black_time_ms", black_time_ms_o, want.black_time_ms);
        if (is_running_o !== want.is_running)
          log_mismatch("is_running", is_running_o, want.is_running);
        if (timeout_side_o !== want.timeout_side)
          log_mismatch("timeout_side", timeout_side_o, want.timeout_side);
      end
    end
  end

  // cycles since the last handshake on either channel
  always @(posedge clk_i) begin : quiet_counter
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  function automatic void push_cmd(input logic [CmdW-1:0] c, input logic [SideW-1:0] s,
                                   input logic [ElapW-1:0] e);
    item_t it;
    it.cmd        = c;
    it.side       = s;
    it.elapsed_ms = e;
    cmd_backlog.push_back(it);
    cmds_owed++;
  endfunction

  // one register write on the config port, mirrored into the predictor
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_TIME_MODE: next_mode = data[ModeW-1:0];
      REG_BASE_TIME: next_base = data[TimeW-1:0];
      REG_INCREMENT: next_inc  = data[IncW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every queued item went in and every result came out,
  // then keep the pipeline idle before the next setting
  task automatic settle();
    do @(negedge clk_i); while (cmds_owed != 0 || clock_readings.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // a game in progress: new game, start, then mostly ticks for the side to
  // move and moves that hand the turn over, with some stops, restarts,
  // fresh games and stray commands mixed in
  task automatic play_game(input int unsigned n);
    logic [SideW-1:0] mover;
    int unsigned      r;
    mover = SIDE_WHITE;
    push_cmd(CMD_NEW, SideW'($urandom), ElapW'($urandom));
    push_cmd(CMD_START, SideW'($urandom), ElapW'($urandom));
    for (int unsigned k = 2; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        push_cmd(CMD_TICK, ($urandom_range(0, 9) == 0) ? SideW'($urandom) : mover,
                 ($urandom_range(0, 3) == 0) ? ElapW'($urandom_range(0, 20))
                                             : ElapW'($urandom));
      end else if (r < 78) begin
        push_cmd(CMD_MOVE, ($urandom_range(0, 9) == 0) ? SideW'($urandom) : mover,
                 ElapW'($urandom));
        mover = (mover == SIDE_WHITE) ? SIDE_BLACK : SIDE_WHITE;
      end else if (r < 84) begin
        push_cmd(CMD_START, SideW'($urandom), ElapW'($urandom));
      end else if (r < 88) begin
        push_cmd(CMD_STOP, SideW'($urandom), ElapW'($urandom));
      end else if (r < 91) begin
        push_cmd(CMD_NEW, SideW'($urandom), ElapW'($urandom));
        mover = SIDE_WHITE;
      end else begin
        push_cmd(CmdW'($urandom), SideW'($urandom), ElapW'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    logic [ModeW-1:0]    mode;
    logic [CfgDataW-1:0] base;
    logic [CfgDataW-1:0] inc;
    int unsigned         r;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // before any new game the clock is disabled: start, tick and move do
    // nothing, stop and an unused command only report the state
    push_cmd(CMD_START, SIDE_WHITE, '0);
    push_cmd(CMD_TICK, SIDE_WHITE, 10'd5);
    push_cmd(CMD_MOVE, SIDE_WHITE, '0);
    push_cmd(CMD_STOP, SIDE_NONE, '0);
    push_cmd(CMD_RSVD + 3'd2, SIDE_BAD, 10'd1023);
    // reset registers give a fischer game: full tick, increment, zero tick,
    // and a move by nobody
    push_cmd(CMD_NEW, SIDE_WHITE, '0);
    push_cmd(CMD_START, SIDE_WHITE, '0);
    push_cmd(CMD_TICK, SIDE_WHITE, 10'd1023);
    push_cmd(CMD_MOVE, SIDE_WHITE, '0);
    push_cmd(CMD_TICK, SIDE_BLACK, '0);
    push_cmd(CMD_MOVE, SIDE_NONE, '0);
    settle();

    // simple delay: partial use, overflow on a tick for nobody, reload on a
    // move by nobody, excess flags white, restart after a flag
    write_reg(REG_TIME_MODE, CfgDataW'(MODE_DELAY));
    write_reg(REG_BASE_TIME, 26'd1000);
    write_reg(REG_INCREMENT, 26'd10);
    push_cmd(CMD_NEW, SIDE_WHITE, '0);
    push_cmd(CMD_START, SIDE_WHITE, '0);
    push_cmd(CMD_TICK, SIDE_WHITE, 10'd5);
    push_cmd(CMD_TICK, SIDE_NONE, 10'd8);
    push_cmd(CMD_MOVE, SIDE_BAD, '0);
    push_cmd(CMD_TICK, SIDE_WHITE, 10'd1023);
    push_cmd(CMD_START, SIDE_BLACK, '0);
    push_cmd(CMD_TICK, SIDE_BLACK, '0);
    settle();

    // bronstein from zero time with an oversized increment: a zero tick flags
    write_reg(REG_TIME_MODE, CfgDataW'(MODE_BRONSTEIN));
    write_reg(REG_BASE_TIME, '0);
    write_reg(REG_INCREMENT, '1);
    push_cmd(CMD_NEW, SIDE_WHITE, '0);
    push_cmd(CMD_START, SIDE_WHITE, '0);
    push_cmd(CMD_TICK, SIDE_BLACK, '0);
    push_cmd(CMD_MOVE, SIDE_WHITE, '0);
    settle();

    // unused mode code with junk above it, base time beyond the maximum
    write_reg(REG_TIME_MODE, {23'h7fffff, MODE_RSVD});
    write_reg(REG_BASE_TIME, '1);
    push_cmd(CMD_NEW, SIDE_WHITE, '0);
    push_cmd(CMD_START, SIDE_WHITE, '0);
    push_cmd(CMD_TICK, SIDE_WHITE, 10'd1023);
    push_cmd(CMD_MOVE, SIDE_WHITE, '0);
    settle();

    // random games, each under a fresh setting and idling pattern
    for (int unsigned p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase

      r = $urandom_range(0, 99);
      if (r < 8) mode = MODE_NONE;
      else if (r < 16) mode = ModeW'(MODE_RSVD + $urandom_range(0, 2));
      else mode = ModeW'(MODE_SUDDEN + $urandom_range(0, 3));

      // small base times so that flags actually happen
      case ($urandom_range(0, 9))
        0: base = '0;
        1: base = CfgDataW'(MAX_TIME_MS);
        2: base = CfgDataW'($urandom);
        default: base = CfgDataW'($urandom_range(1, 8000));
      endcase
      case ($urandom_range(0, 9))
        0: inc = '0;
        1: inc = CfgDataW'(MAX_INC_MS);
        2: inc = CfgDataW'($urandom);  // bits above the register are dropped
        default: inc = CfgDataW'($urandom_range(0, 3000));
      endcase
      // one game at the top of both ranges
      if (p == 0) begin
        mode = MODE_FISCHER;
        base = CfgDataW'(MAX_TIME_MS);
        inc  = CfgDataW'(MAX_INC_MS);
      end

      write_reg(REG_TIME_MODE,
                {($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'd0, mode});
      write_reg(REG_BASE_TIME, base);
      write_reg(REG_INCREMENT, inc);
      play_game(120);
      settle();
    end

    repeat (8) @(negedge clk_i);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
